FILE: design/cit_pkg.sv
// ----------------------------------------------------------------------------
// cit_pkg: shared types and constants of the cascaded interval timer
// Opcodes, register offsets, control bit positions, the item and result
// structs, and the control register write function.
// ----------------------------------------------------------------------------
package cit_pkg;

   localparam int unsigned OpcodeWidth = 2;
   localparam int unsigned OffsetWidth = 3;
   localparam int unsigned DataWidth   = 32;
   localparam int unsigned CtrlWidth   = 12;
   localparam int unsigned CountWidth  = 2 * DataWidth;

   // opcodes
   localparam logic [OpcodeWidth-1:0] OP_TICK  = 2'd0;
   localparam logic [OpcodeWidth-1:0] OP_READ  = 2'd1;
   localparam logic [OpcodeWidth-1:0] OP_WRITE = 2'd2;

   // register offsets (word index)
   localparam logic [OffsetWidth-1:0] REG_CTRL_LO  = 3'd0;
   localparam logic [OffsetWidth-1:0] REG_LOAD_LO  = 3'd1;
   localparam logic [OffsetWidth-1:0] REG_COUNT_LO = 3'd2;
   localparam logic [OffsetWidth-1:0] REG_CTRL_HI  = 3'd4;
   localparam logic [OffsetWidth-1:0] REG_LOAD_HI  = 3'd5;
   localparam logic [OffsetWidth-1:0] REG_COUNT_HI = 3'd6;

   // control bit positions
   localparam int unsigned BIT_DOWN = 1;
   localparam int unsigned BIT_ARLD = 4;
   localparam int unsigned BIT_LOAD = 5;
   localparam int unsigned BIT_ENIT = 6;
   localparam int unsigned BIT_EN   = 7;
   localparam int unsigned BIT_INT  = 8;

   typedef logic [CtrlWidth-1:0]  ctrl_type;
   typedef logic [DataWidth-1:0]  word_type;
   typedef logic [CountWidth-1:0] count_type;

   typedef struct packed {
      logic [OpcodeWidth-1:0] opcode;
      logic [OffsetWidth-1:0] reg_offset;
      word_type               write_data;
   } item_type;

   typedef struct packed {
      word_type read_data;
      logic     interrupt_out;
   } result_type;

   // Store the written bits; a 1 in the flag position clears the flag.
   function automatic ctrl_type ctrl_write(input ctrl_type old_value, input word_type data);
      ctrl_type value;
      begin
         value          = data[CtrlWidth-1:0];
         value[BIT_INT] = old_value[BIT_INT] & ~data[BIT_INT];
         return value;
      end
   endfunction

endpackage

FILE: design/cit_exec.sv
// ----------------------------------------------------------------------------
// cit_exec: timer register file and combinational execute logic
// Holds the control, load and count registers and applies one tick, read or
// write per advance, producing the read data and interrupt line of the item.
// ----------------------------------------------------------------------------
module cit_exec (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  cit_pkg::item_type   item,
   output cit_pkg::result_type result
);
   import cit_pkg::*;

   ctrl_type  ctrl_lo_ff,  ctrl_lo_in;
   ctrl_type  ctrl_hi_ff,  ctrl_hi_in;
   word_type  load_lo_ff,  load_lo_in;
   word_type  load_hi_ff,  load_hi_in;
   count_type count_ff,    count_in;

   logic      down;
   logic      at_terminal;
   count_type count_step;
   word_type  read_value;

   assign down        = ctrl_lo_ff[BIT_DOWN];
   assign at_terminal = down ? (count_ff == '0) : (&count_ff);
   // one adder: add all ones to count down
   assign count_step  = count_ff + (down ? {CountWidth{1'b1}} : count_type'(1));

   always_comb begin
      ctrl_lo_in = ctrl_lo_ff;
      ctrl_hi_in = ctrl_hi_ff;
      load_lo_in = load_lo_ff;
      load_hi_in = load_hi_ff;
      count_in   = count_ff;
      read_value = '0;
      unique case (item.opcode)
         OP_TICK: begin
            if (ctrl_lo_ff[BIT_LOAD] || ctrl_hi_ff[BIT_LOAD]) begin
               if (ctrl_lo_ff[BIT_LOAD]) count_in[DataWidth-1:0] = load_lo_ff;
               if (ctrl_hi_ff[BIT_LOAD]) count_in[CountWidth-1:DataWidth] = load_hi_ff;
            end else if (ctrl_lo_ff[BIT_EN]) begin
               if (at_terminal) begin
                  ctrl_lo_in[BIT_INT] = 1'b1;
                  if (ctrl_lo_ff[BIT_ARLD]) count_in = {load_hi_ff, load_lo_ff};
               end else begin
                  count_in = count_step;
               end
            end
         end
         OP_READ: begin
            unique case (item.reg_offset)
               REG_CTRL_LO:  read_value = word_type'(ctrl_lo_ff);
               REG_LOAD_LO:  read_value = load_lo_ff;
               REG_COUNT_LO: read_value = count_ff[DataWidth-1:0];
               REG_CTRL_HI:  read_value = word_type'(ctrl_hi_ff);
               REG_LOAD_HI:  read_value = load_hi_ff;
               REG_COUNT_HI: read_value = count_ff[CountWidth-1:DataWidth];
               default:      read_value = '0;
            endcase
         end
         OP_WRITE: begin
            unique case (item.reg_offset)
               REG_CTRL_LO: begin
                  ctrl_lo_in = ctrl_write(ctrl_lo_ff, item.write_data);
                  if (ctrl_lo_in[BIT_LOAD]) count_in[DataWidth-1:0] = load_lo_ff;
               end
               REG_LOAD_LO: load_lo_in = item.write_data;
               REG_CTRL_HI: begin
                  ctrl_hi_in = ctrl_write(ctrl_hi_ff, item.write_data);
                  if (ctrl_hi_in[BIT_LOAD]) count_in[CountWidth-1:DataWidth] = load_hi_ff;
               end
               REG_LOAD_HI: load_hi_in = item.write_data;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign result.read_data     = read_value;
   assign result.interrupt_out = ctrl_lo_in[BIT_INT] & ctrl_lo_in[BIT_ENIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_lo_ff <= '0;
         ctrl_hi_ff <= '0;
         load_lo_ff <= '0;
         load_hi_ff <= '0;
         count_ff   <= '0;
      end else if (advance) begin
         ctrl_lo_ff <= ctrl_lo_in;
         ctrl_hi_ff <= ctrl_hi_in;
         load_lo_ff <= load_lo_in;
         load_hi_ff <= load_hi_in;
         count_ff   <= count_in;
      end
   end

endmodule

FILE: design/cascaded_interval_timer_regs.sv
// ----------------------------------------------------------------------------
// cascaded_interval_timer_regs: 64-bit cascaded interval timer, item driven
// Input register, combinational execute stage and result register.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel is a clock tick, a register read or a
// register write, and gives exactly one transfer on the rsp_ channel with the
// read data (zero unless a read of a used offset) and the interrupt line as it
// stands after that item. One item is taken every cycle unless a stalled response
// backs up the input register; an accepted request passes through the input
// register and the result register around the execute logic (a 64-bit
// increment or decrement and terminal compare). A request is taken while a
// finished response still waits, as long as the input register can move on.
module cascaded_interval_timer_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cit_pkg::OpcodeWidth-1:0]      req_opcode,
   input  logic [cit_pkg::OffsetWidth-1:0]      req_reg_offset,
   input  logic [cit_pkg::DataWidth-1:0]        req_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cit_pkg::DataWidth-1:0]        rsp_read_data,
   output logic                                 rsp_interrupt_out
);
   import cit_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   result_type exec_result;
   logic       accept;
   logic       advance;

   // move the staged item on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   cit_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (exec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.opcode     <= req_opcode;
         in_item_ff.reg_offset <= req_reg_offset;
         in_item_ff.write_data <= req_write_data;
      end
      if (advance) begin
         out_result_ff <= exec_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_result_ff.read_data;
   assign rsp_interrupt_out = out_result_ff.interrupt_out;

`ifndef SYNTH
   a_stall_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting response");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("executed item left no response");

   a_empty_stage_takes_item: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("empty input register stalled the request channel");
`endif

endmodule

FILE: tb/cascaded_interval_timer_regs_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_interval_timer_regs_test: self-checking bench for the 64-bit timer
// Drives ticks, register reads and register writes through the req_ channel
// and compares every rsp_ transfer against a cycle-free model of the timer
// kept in a small scoreboard. A short directed run covers the corner cases,
// then random programmed count sequences mixed with noise follow.
// ----------------------------------------------------------------------------
module cascaded_interval_timer_regs_test;
   import cit_pkg::*;

   localparam int unsigned ClockPeriod = 10;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned ItemTarget  = 850;
   localparam int unsigned ReportLimit = 40;

   // codes the package does not name
   localparam logic [OpcodeWidth-1:0] OP_UNUSED    = 2'd3;
   localparam logic [OffsetWidth-1:0] REG_SPARE_LO = 3'd3;
   localparam logic [OffsetWidth-1:0] REG_SPARE_HI = 3'd7;
   localparam word_type               ALL_ONES     = 32'hFFFF_FFFF;

   class timer_scoreboard;
      ctrl_type    ctrl_lo;
      ctrl_type    ctrl_hi;
      word_type    load_lo;
      word_type    load_hi;
      count_type   count;
      result_type  expected_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned ticks;
      int unsigned reads;
      int unsigned writes;
      int unsigned wraps;

      function new();
         ctrl_lo = '0;
         ctrl_hi = '0;
         load_lo = '0;
         load_hi = '0;
         count   = '0;
         errors  = 0;
         checked = 0;
         ticks   = 0;
         reads   = 0;
         writes  = 0;
         wraps   = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // a 1 in the flag position clears the flag, a 0 keeps it
      function ctrl_type merge_control(ctrl_type old_value, word_type data);
         ctrl_type flag_mask;
         flag_mask          = '0;
         flag_mask[BIT_INT] = 1'b1;
         return (data[CtrlWidth-1:0] & ~flag_mask) | (old_value & flag_mask & ~data[CtrlWidth-1:0]);
      endfunction

      function void advance_counter();
         count_type terminal;
         ticks++;
         if (ctrl_lo[BIT_LOAD] || ctrl_hi[BIT_LOAD]) begin
            if (ctrl_lo[BIT_LOAD]) count[DataWidth-1:0] = load_lo;
            if (ctrl_hi[BIT_LOAD]) count[CountWidth-1:DataWidth] = load_hi;
            return;
         end
         if (!ctrl_lo[BIT_EN]) return;
         terminal = '0;
         if (!ctrl_lo[BIT_DOWN]) terminal = '1;
         if (count == terminal) begin
            wraps++;
            ctrl_lo[BIT_INT] = 1'b1;
            if (ctrl_lo[BIT_ARLD]) count = {load_hi, load_lo};
         end else if (ctrl_lo[BIT_DOWN]) begin
            count = count - 1'b1;
         end else begin
            count = count + 1'b1;
         end
      endfunction

      function void note_request(logic [OpcodeWidth-1:0] op, logic [OffsetWidth-1:0] off,
                                 word_type data);
         result_type r;
         r.read_data = '0;
         case (op)
            OP_TICK: advance_counter();
            OP_READ: begin
               reads++;
               case (off)
                  REG_CTRL_LO:  r.read_data = word_type'(ctrl_lo);
                  REG_LOAD_LO:  r.read_data = load_lo;
                  REG_COUNT_LO: r.read_data = count[DataWidth-1:0];
                  REG_CTRL_HI:  r.read_data = word_type'(ctrl_hi);
                  REG_LOAD_HI:  r.read_data = load_hi;
                  REG_COUNT_HI: r.read_data = count[CountWidth-1:DataWidth];
                  default:      r.read_data = '0;
               endcase
            end
            OP_WRITE: begin
               writes++;
               case (off)
                  REG_CTRL_LO: begin
                     ctrl_lo = merge_control(ctrl_lo, data);
                     if (ctrl_lo[BIT_LOAD]) count[DataWidth-1:0] = load_lo;
                  end
                  REG_LOAD_LO: load_lo = data;
                  REG_CTRL_HI: begin
                     ctrl_hi = merge_control(ctrl_hi, data);
                     if (ctrl_hi[BIT_LOAD]) count[CountWidth-1:DataWidth] = load_hi;
                  end
                  REG_LOAD_HI: load_hi = data;
                  default: ;
               endcase
            end
            default: ;
         endcase
         r.interrupt_out = ctrl_lo[BIT_INT] & ctrl_lo[BIT_ENIT];
         expected_q.push_back(r);
      endfunction

      function void check_response(word_type rd, logic irq);
         result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: response with nothing expected, expected none, actual %h/%b",
                        $time, rd, irq);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (rd !== want.read_data) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: read_data mismatch, expected %h, actual %h",
                        $time, want.read_data, rd);
         end
         if (irq !== want.interrupt_out) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: interrupt_out mismatch, expected %b, actual %b",
                        $time, want.interrupt_out, irq);
         end
      endfunction
   endclass

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic [OpcodeWidth-1:0] req_opcode        = OP_TICK;
   logic [OffsetWidth-1:0] req_reg_offset    = REG_CTRL_LO;
   word_type               req_write_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   word_type               rsp_read_data;
   logic                   rsp_interrupt_out;

   timer_scoreboard sb;
   int unsigned     items_sent = 0;
   int unsigned     burst_left = 0;
   int unsigned     cycle_count = 0;
   int unsigned     rx_cycle = 0;
   int unsigned     rx_seg_left = 0;
   int unsigned     rx_mode = 0;
   logic            rx_stall_next;

   cascaded_interval_timer_regs DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_reg_offset    (req_reg_offset),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_interrupt_out (rsp_interrupt_out)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timed out with %0d responses outstanding", $time, sb.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: check each transfer, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_read_data, rsp_interrupt_out);
         rx_cycle++;
         if (rx_seg_left == 0) begin
            rx_mode     = $urandom_range(0, 3);
            rx_seg_left = $urandom_range(10, 60);
         end
         rx_seg_left--;
         if ((rx_cycle >= 300 && rx_cycle < 390) || (rx_cycle >= 1600 && rx_cycle < 1690)) begin
            // long hold-off so the pipeline fills and backs up the sender
            rx_stall_next = 1'b1;
         end else begin
            case (rx_mode)
               0:       rx_stall_next = 1'b0;
               1:       rx_stall_next = ($urandom_range(0, 3) == 0);
               2:       rx_stall_next = ($urandom_range(0, 3) != 0);
               default: rx_stall_next = rx_cycle[0];
            endcase
         end
         rsp_stall <= rx_stall_next;
      end
   end

   function automatic word_type ctrl_word(bit down, bit arld, bit load, bit enit, bit en,
                                          bit clear_flag);
      word_type w;
      w           = '0;
      w[BIT_DOWN] = down;
      w[BIT_ARLD] = arld;
      w[BIT_LOAD] = load;
      w[BIT_ENIT] = enit;
      w[BIT_EN]   = en;
      w[BIT_INT]  = clear_flag;
      return w;
   endfunction

   function automatic word_type spare_bits();
      return word_type'($urandom) & ~ctrl_word(1, 1, 1, 1, 1, 1);
   endfunction

   task automatic send_item(input logic [OpcodeWidth-1:0] op, input logic [OffsetWidth-1:0] off,
                            input word_type data);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_reg_offset <= off;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, off, data);
      if (!(op == OP_UNUSED ||
            (op == OP_WRITE && off inside {REG_COUNT_LO, REG_COUNT_HI, REG_SPARE_LO, REG_SPARE_HI})))
         items_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // program the load halves, load them, then run the counter with reads mixed in
   task automatic run_count_sequence();
      bit          down;
      bit          arld;
      bit          enit;
      bit          hold_load;
      word_type    lo;
      word_type    hi;
      word_type    extra;
      int unsigned pick;
      down  = 1'($urandom_range(0, 1));
      arld  = 1'($urandom_range(0, 1));
      enit  = ($urandom_range(0, 3) != 0);
      extra = spare_bits();
      pick  = $urandom_range(0, 3);
      if (pick == 3) begin
         hi = $urandom;
         lo = $urandom;
      end else begin
         // start close to the terminal value; sometimes only in the low half
         hi = down ? '0 : ALL_ONES;
         if (pick == 2) hi = $urandom;
         lo = down ? word_type'($urandom_range(0, 12)) : ~word_type'($urandom_range(0, 12));
      end
      send_item(OP_WRITE, REG_LOAD_LO, lo);
      send_item(OP_WRITE, REG_LOAD_HI, hi);
      send_item(OP_WRITE, REG_CTRL_HI,
                ctrl_word(0, 0, 1, 0, 0, 1'($urandom_range(0, 1))) | spare_bits());
      send_item(OP_WRITE, REG_CTRL_LO,
                ctrl_word(down, arld, 1, enit, 1, 1'($urandom_range(0, 1))) | extra);
      if ($urandom_range(0, 2) == 0) send_item(OP_TICK, REG_CTRL_LO, $urandom);
      send_item(OP_WRITE, REG_CTRL_HI,
                ctrl_word(0, 0, 0, 0, 0, 1'($urandom_range(0, 1))) | spare_bits());
      hold_load = ($urandom_range(0, 7) == 0);
      send_item(OP_WRITE, REG_CTRL_LO,
                ctrl_word(down, arld, hold_load, enit, $urandom_range(0, 7) != 0,
                          1'($urandom_range(0, 1))) | extra);
      repeat ($urandom_range(4, 24)) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            send_item(OP_TICK, OffsetWidth'($urandom_range(0, 7)), $urandom);
         end else if (pick <= 7) begin
            send_item(OP_READ, OffsetWidth'($urandom_range(0, 7)), $urandom);
         end else if (pick == 8) begin
            down = 1'($urandom_range(0, 1));
            send_item(OP_WRITE, REG_CTRL_LO, ctrl_word(down, arld, 0, enit, 1, 1) | extra);
         end else begin
            send_item(OP_WRITE, ($urandom_range(0, 1) == 0) ? REG_LOAD_LO : REG_LOAD_HI, $urandom);
         end
      end
      send_item(OP_READ, REG_COUNT_LO, $urandom);
      send_item(OP_READ, REG_COUNT_HI, $urandom);
   endtask

   initial begin
      bit paused;
      paused = 1'b0;
      sb     = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_item(OP_READ,   REG_CTRL_LO,  ALL_ONES);
      send_item(OP_WRITE,  REG_COUNT_HI, ALL_ONES);   // read-only, drop
      send_item(OP_WRITE,  REG_SPARE_LO, ALL_ONES);
      send_item(OP_UNUSED, REG_SPARE_HI, ALL_ONES);
      send_item(OP_READ,   REG_SPARE_LO, '0);
      send_item(OP_WRITE,  REG_LOAD_HI,  ALL_ONES);
      send_item(OP_WRITE,  REG_LOAD_LO,  ALL_ONES);
      send_item(OP_WRITE,  REG_CTRL_HI,  ALL_ONES);   // loads high half, flag never stored
      send_item(OP_READ,   REG_CTRL_HI,  '0);
      send_item(OP_WRITE,  REG_CTRL_LO,  ctrl_word(0, 0, 1, 0, 0, 0));
      send_item(OP_TICK,   REG_CTRL_LO,  '0);         // load held, no count
      send_item(OP_WRITE,  REG_CTRL_HI,  '0);
      send_item(OP_WRITE,  REG_CTRL_LO,  ctrl_word(0, 0, 0, 1, 1, 0));
      send_item(OP_TICK,   REG_CTRL_LO,  '0);         // all ones, no reload: hold
      send_item(OP_TICK,   REG_CTRL_LO,  '0);         // flag again while held
      send_item(OP_READ,   REG_COUNT_LO, '0);
      send_item(OP_WRITE,  REG_LOAD_HI,  '0);
      send_item(OP_WRITE,  REG_LOAD_LO,  32'd1);
      send_item(OP_WRITE,  REG_CTRL_LO,  ctrl_word(0, 1, 0, 1, 1, 1));
      send_item(OP_TICK,   REG_CTRL_LO,  '0);         // wrap up with reload
      send_item(OP_WRITE,  REG_CTRL_LO,  ctrl_word(1, 1, 0, 1, 1, 1));
      send_item(OP_TICK,   REG_CTRL_LO,  '0);
      send_item(OP_TICK,   REG_CTRL_LO,  '0);         // wrap down at zero with reload
      send_item(OP_READ,   REG_COUNT_LO, '0);
      send_item(OP_WRITE,  REG_CTRL_LO,  ctrl_word(0, 0, 0, 0, 0, 1));
      wait_drain();

      while (items_sent < ItemTarget) begin
         if ($urandom_range(0, 4) != 0) begin
            run_count_sequence();
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(OpcodeWidth'($urandom_range(0, 3)),
                         OffsetWidth'($urandom_range(0, 7)), $urandom);
         end
         if (!paused && items_sent >= ItemTarget / 2) begin
            wait_drain();
            paused = 1'b1;
         end
      end

      wait_drain();
      repeat (8) @(posedge clock);
      $display("Ran %0d items: %0d ticks, %0d reads, %0d writes, %0d terminal hits",
               items_sent, sb.ticks, sb.reads, sb.writes, sb.wraps);
      $display("Checked %0d responses, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: cascaded_interval_timer_regs.f
design/cit_pkg.sv
design/cit_exec.sv
design/cascaded_interval_timer_regs.sv
tb/cascaded_interval_timer_regs_test.sv
